// ----- design/i2cm_pkg.sv -----
// Package: shared types, sequencer step codes and register indexes for the I2C master bit engine.
`timescale 1ns / 1ps

package i2cm_pkg;

   localparam logic [15:0] HALF_PERIOD_RESET   = 16'd24;
   localparam logic [7:0]  STRETCH_LIMIT_RESET = 8'd2;
   localparam logic [7:0]  STRETCH_SATURATE    = 8'd255;
   localparam logic [3:0]  BITS_PER_BYTE       = 4'd8;

   // configuration register indexes
   localparam logic CSR_HALF_PERIOD   = 1'b0;
   localparam logic CSR_STRETCH_LIMIT = 1'b1;

   // command codes
   typedef enum logic [1:0] {
      MODE_START = 2'd0,
      MODE_STOP  = 2'd1,
      MODE_WRITE = 2'd2,
      MODE_READ  = 2'd3
   } mode_type;

   // sequencer steps; each SCL wait step is followed directly by its successor code
   typedef enum logic [4:0] {
      Q_IDLE   = 5'd0,
      Q_FIN    = 5'd1,
      Q_ST_A   = 5'd2,
      Q_ST_B   = 5'd3,
      Q_ST_BW  = 5'd4,
      Q_ST_C   = 5'd5,
      Q_ST_D   = 5'd6,
      Q_SP_A   = 5'd7,
      Q_SP_B   = 5'd8,
      Q_SP_BW  = 5'd9,
      Q_SP_C   = 5'd10,
      Q_W_BIT  = 5'd11,
      Q_W_HI   = 5'd12,
      Q_W_HIW  = 5'd13,
      Q_W_LO   = 5'd14,
      Q_W_AREL = 5'd15,
      Q_W_AHI  = 5'd16,
      Q_W_AHIW = 5'd17,
      Q_W_ALO  = 5'd18,
      Q_R_REL  = 5'd19,
      Q_R_HI   = 5'd20,
      Q_R_HIW  = 5'd21,
      Q_R_LO   = 5'd22,
      Q_R_ACK  = 5'd23,
      Q_R_AHI  = 5'd24,
      Q_R_AHIW = 5'd25,
      Q_R_ALO  = 5'd26,
      Q_R_END  = 5'd27
   } step_type;

   typedef struct packed {
      logic       cmd_valid;
      logic [1:0] mode;
      logic [7:0] write_byte;
      logic       send_ack;
      logic       scl_level;
      logic       sda_level;
      logic       ms_strobe;
   } req_type;

   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_byte;
      logic       ack_seen;
      logic       bus_error;
   } rsp_type;

endpackage

// ----- design/i2cm_seq.sv -----
// Bit-timing sequencer: configuration registers, engine state and the per-tick step logic.
`timescale 1ns / 1ps

module i2cm_seq
   import i2cm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [15:0] csr_write_data,
   input  logic        step_en,
   input  req_type     req,
   output rsp_type     rsp
);

   logic [15:0] half_period_ff, half_period_in;
   logic [7:0]  stretch_limit_ff, stretch_limit_in;

   step_type    step_ff, step_in;
   logic [3:0]  bit_ff, bit_in;
   logic [7:0]  shift_ff, shift_in;
   logic [15:0] delay_ff, delay_in;
   logic [7:0]  stretch_ff, stretch_in;
   logic        scl_ff, scl_in;
   logic        sda_ff, sda_in;
   logic [1:0]  op_ff, op_in;
   logic        ack_send_ff, ack_send_in;
   logic        ack_latch_ff, ack_latch_in;

   always_comb begin
      half_period_in   = half_period_ff;
      stretch_limit_in = stretch_limit_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_HALF_PERIOD:   half_period_in   = csr_write_data;
            CSR_STRETCH_LIMIT: stretch_limit_in = csr_write_data[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      logic [7:0] lim;
      logic       done;
      logic       err;
      logic [7:0] rbyte;
      logic       ack;
      step_type   nxt;

      step_in      = step_ff;
      bit_in       = bit_ff;
      shift_in     = shift_ff;
      delay_in     = delay_ff;
      stretch_in   = stretch_ff;
      scl_in       = scl_ff;
      sda_in       = sda_ff;
      op_in        = op_ff;
      ack_send_in  = ack_send_ff;
      ack_latch_in = ack_latch_ff;
      done         = 1'b0;
      err          = 1'b0;
      rbyte        = 8'd0;
      ack          = 1'b0;
      lim          = (stretch_limit_ff == 8'd0) ? 8'd1 : stretch_limit_ff;
      nxt          = step_type'(5'(step_ff) + 5'd1);

      if (step_ff == Q_IDLE && req.cmd_valid) begin
         op_in        = req.mode;
         shift_in     = (mode_type'(req.mode) == MODE_WRITE) ? req.write_byte : 8'd0;
         ack_send_in  = req.send_ack;
         ack_latch_in = 1'b0;
         bit_in       = 4'd0;
         delay_in     = 16'd0;
         stretch_in   = 8'd0;
         unique case (mode_type'(req.mode))
            MODE_START: step_in = Q_ST_A;
            MODE_STOP:  step_in = Q_SP_A;
            MODE_WRITE: step_in = Q_W_BIT;
            MODE_READ:  step_in = Q_R_REL;
            default:    step_in = Q_IDLE;
         endcase
         nxt = step_type'(5'(step_in) + 5'd1);
      end

      if (step_in != Q_IDLE) begin
         if (delay_in != 16'd0) begin
            delay_in = delay_in - 16'd1;
         end else begin
            unique case (step_in)
               Q_ST_BW, Q_SP_BW, Q_W_HIW, Q_W_AHIW, Q_R_HIW, Q_R_AHIW: begin
                  if (req.scl_level) begin
                     delay_in = half_period_ff;
                     step_in  = nxt;
                  end else if (req.ms_strobe) begin
                     if (stretch_in != STRETCH_SATURATE) begin
                        stretch_in = stretch_in + 8'd1;
                     end
                     if (stretch_in >= lim) begin
                        if (step_in == Q_SP_BW) begin
                           delay_in = 16'd0;
                           step_in  = nxt;
                        end else begin
                           done    = 1'b1;
                           err     = 1'b1;
                           step_in = Q_IDLE;
                        end
                     end
                  end
               end
               Q_ST_A: begin
                  sda_in = 1'b1; delay_in = half_period_ff; step_in = Q_ST_B;
               end
               Q_ST_C: begin
                  sda_in = 1'b0; delay_in = half_period_ff; step_in = Q_ST_D;
               end
               Q_SP_A: begin
                  sda_in = 1'b0; delay_in = half_period_ff; step_in = Q_SP_B;
               end
               Q_SP_C: begin
                  sda_in = 1'b1; delay_in = half_period_ff; step_in = Q_FIN;
               end
               Q_W_BIT: begin
                  sda_in = shift_in[7]; delay_in = half_period_ff; step_in = Q_W_HI;
               end
               Q_W_AREL: begin
                  sda_in = 1'b1; delay_in = half_period_ff; step_in = Q_W_AHI;
               end
               Q_R_REL: begin
                  sda_in = 1'b1; delay_in = half_period_ff; step_in = Q_R_HI;
               end
               Q_R_ACK: begin
                  sda_in = ~ack_send_in; delay_in = half_period_ff; step_in = Q_R_AHI;
               end
               Q_R_END: begin
                  sda_in = 1'b1; delay_in = half_period_ff; step_in = Q_FIN;
               end
               Q_ST_B, Q_SP_B, Q_W_HI, Q_W_AHI, Q_R_HI, Q_R_AHI: begin
                  scl_in     = 1'b1;
                  stretch_in = 8'd0;
                  delay_in   = 16'd0;
                  step_in    = nxt;
               end
               Q_ST_D: begin
                  scl_in = 1'b0; delay_in = half_period_ff; step_in = Q_FIN;
               end
               Q_W_LO: begin
                  shift_in = {shift_in[6:0], 1'b0};
                  bit_in   = bit_in + 4'd1;
                  scl_in   = 1'b0;
                  delay_in = half_period_ff;
                  step_in  = (bit_in < BITS_PER_BYTE) ? Q_W_BIT : Q_W_AREL;
               end
               Q_W_ALO: begin
                  ack_latch_in = ~req.sda_level;
                  scl_in       = 1'b0;
                  delay_in     = half_period_ff;
                  step_in      = Q_FIN;
               end
               Q_R_LO: begin
                  shift_in = {shift_in[6:0], req.sda_level};
                  bit_in   = bit_in + 4'd1;
                  scl_in   = 1'b0;
                  delay_in = half_period_ff;
                  step_in  = (bit_in < BITS_PER_BYTE) ? Q_R_HI : Q_R_ACK;
               end
               Q_R_ALO: begin
                  scl_in = 1'b0; delay_in = half_period_ff; step_in = Q_R_END;
               end
               Q_FIN: begin
                  done = 1'b1;
                  if (mode_type'(op_in) == MODE_WRITE) begin
                     ack = ack_latch_in;
                  end
                  if (mode_type'(op_in) == MODE_READ) begin
                     rbyte = shift_in;
                  end
                  step_in = Q_IDLE;
               end
               default: step_in = Q_IDLE;
            endcase
         end
      end

      rsp.scl_out   = scl_in;
      rsp.sda_out   = sda_in;
      rsp.busy_res  = (step_in != Q_IDLE);
      rsp.done_res  = done;
      rsp.read_byte = rbyte;
      rsp.ack_seen  = ack;
      rsp.bus_error = err;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff   <= HALF_PERIOD_RESET;
         stretch_limit_ff <= STRETCH_LIMIT_RESET;
      end else begin
         half_period_ff   <= half_period_in;
         stretch_limit_ff <= stretch_limit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= Q_IDLE;
         bit_ff       <= 4'd0;
         shift_ff     <= 8'd0;
         delay_ff     <= 16'd0;
         stretch_ff   <= 8'd0;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         op_ff        <= 2'd0;
         ack_send_ff  <= 1'b0;
         ack_latch_ff <= 1'b0;
      end else if (step_en) begin
         step_ff      <= step_in;
         bit_ff       <= bit_in;
         shift_ff     <= shift_in;
         delay_ff     <= delay_in;
         stretch_ff   <= stretch_in;
         scl_ff       <= scl_in;
         sda_ff       <= sda_in;
         op_ff        <= op_in;
         ack_send_ff  <= ack_send_in;
         ack_latch_ff <= ack_latch_in;
      end
   end

`ifndef SYNTHESIS
   a_err_with_done: assert property (@(posedge clock) disable iff (reset)
      rsp.bus_error |-> (rsp.done_res && !rsp.busy_res))
      else $error("bus error without done");

   a_idle_follows_busy: assert property (@(posedge clock) disable iff (reset)
      step_en |=> ((step_ff == Q_IDLE) == !$past(rsp.busy_res)))
      else $error("engine state disagrees with reported busy");

   a_bit_count_range: assert property (@(posedge clock) disable iff (reset)
      step_en |=> (bit_ff <= BITS_PER_BYTE))
      else $error("bit counter ran past a byte");
`endif

endmodule

// ----- design/i2cm_out.sv -----
// Result register: holds one result beat and decides when the sequencer may advance.
`timescale 1ns / 1ps

module i2cm_out
   import i2cm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    step_en,
   input  rsp_type rsp_next,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp
);

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   assign req_stall = valid_ff && rsp_stall;
   assign step_en   = req_valid && !req_stall;
   assign valid_in  = step_en || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         data_ff <= rsp_next;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp       = data_ff;

`ifndef SYNTHESIS
   a_beat_lands: assert property (@(posedge clock) disable iff (reset)
      step_en |=> valid_ff)
      else $error("accepted beat left no result");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && rsp_stall) |-> !step_en)
      else $error("held result overwritten");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !rsp_stall && !req_valid) |=> !valid_ff)
      else $error("result repeated after delivery");
`endif

endmodule

// ----- design/i2c_master_bit_engine.sv -----
// Top level of the I2C master bit engine: port mapping around the sequencer and result register.
`timescale 1ns / 1ps

// Each request beat is one clock tick of the I2C bit sequencer, and each beat yields exactly one
// response beat carrying the line drives and status after that tick. A beat is taken every cycle
// unless stalled; the whole step is computed in one pass from the engine state and lands in the
// result register, so a response appears in the cycle after its request. The request side stalls
// only while a finished result is held by a stalled response side. Bus timing is set entirely by
// the beat count: half_period beats after every line change and stretch_limit_ms ms_strobe beats
// of SCL held low before a bus error. Configuration writes take effect on the next cycle.

module i2c_master_bit_engine
   import i2cm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [15:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_cmd_valid,
   input  logic [1:0]  req_mode,
   input  logic [7:0]  req_write_byte,
   input  logic        req_send_ack,
   input  logic        req_scl_level,
   input  logic        req_sda_level,
   input  logic        req_ms_strobe,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_scl_out,
   output logic        rsp_sda_out,
   output logic        rsp_busy_res,
   output logic        rsp_done_res,
   output logic [7:0]  rsp_read_byte,
   output logic        rsp_ack_seen,
   output logic        rsp_bus_error
);

   req_type req;
   rsp_type rsp_next;
   rsp_type rsp;
   logic    step_en;

   assign req.cmd_valid  = req_cmd_valid;
   assign req.mode       = req_mode;
   assign req.write_byte = req_write_byte;
   assign req.send_ack   = req_send_ack;
   assign req.scl_level  = req_scl_level;
   assign req.sda_level  = req_sda_level;
   assign req.ms_strobe  = req_ms_strobe;

   i2cm_seq u_seq (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .step_en          (step_en),
      .req              (req),
      .rsp              (rsp_next)
   );

   i2cm_out u_out (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .step_en   (step_en),
      .rsp_next  (rsp_next),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   assign rsp_scl_out   = rsp.scl_out;
   assign rsp_sda_out   = rsp.sda_out;
   assign rsp_busy_res  = rsp.busy_res;
   assign rsp_done_res  = rsp.done_res;
   assign rsp_read_byte = rsp.read_byte;
   assign rsp_ack_seen  = rsp.ack_seen;
   assign rsp_bus_error = rsp.bus_error;

endmodule
